### rtl/core/tcg_pkg.sv
`timescale 1ns / 1ps
package tcg_pkg;

  localparam int GLYPH_LIMIT = 1024;
  localparam int GCNT_W      = $clog2(GLYPH_LIMIT + 1);
  localparam int GNUM_W      = 10;
  localparam int DIV_STEPS   = 16;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [7:0]  CODE_NEWLINE = 8'h0A;
  localparam logic [7:0]  CODE_ESCAPE  = 8'h1B;
  localparam logic [7:0]  CODE_SPACE   = 8'h20;
  localparam logic [31:0] COLOR_WHITE  = 32'hFFFF_FFFF;

  localparam logic [7:0] FIRST_CODE_RST = 8'd32;
  localparam logic [7:0] TABLE_SIZE_RST = 8'd95;

  localparam int CFG_ADDR_W = 3;

  // Work handed from the front to the back: everything but the texture coordinates.
  typedef struct packed {
    logic [7:0]        col;
    logic [7:0]        row;
    logic [31:0]       color;
    logic [7:0]        k;
    logic [GNUM_W-1:0] glyph_number;
    logic              limit_hit;
  } job_t;

  typedef struct packed {
    logic              stopped;
    logic [GCNT_W-1:0] glyph_total;
  } front_stat_t;

  function automatic logic [7:0] widen2(input logic [1:0] v);
    widen2 = {v, v, v, v};
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

### rtl/core/tcg_in_if.sv
`timescale 1ns / 1ps
interface tcg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       frame_start;

  modport source (output valid, output text_byte, output frame_start, input ready);
  modport sink   (input valid, input text_byte, input frame_start, output ready);
endinterface

### rtl/core/tcg_out_if.sv
`timescale 1ns / 1ps
interface tcg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cell_column;
  logic [7:0]  cell_row;
  logic [15:0] tex_left;
  logic [15:0] tex_right;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [9:0]  glyph_number;
  logic        limit_hit;

  modport source (output valid, output cell_column, output cell_row, output tex_left,
                  output tex_right, output red, output green, output blue, output alpha,
                  output glyph_number, output limit_hit, input ready);
  modport sink   (input valid, input cell_column, input cell_row, input tex_left,
                  input tex_right, input red, input green, input blue, input alpha,
                  input glyph_number, input limit_hit, output ready);
endinterface

### rtl/core/tcg_front.sv
`timescale 1ns / 1ps
module tcg_front (
  input  logic                 clk,
  input  logic                 rst_n,
  tcg_in_if.sink               in_chan,
  input  logic [7:0]           first_code,
  input  logic [7:0]           table_size,
  input  logic                 q_full,
  output logic                 push,
  output tcg_pkg::job_t        push_job,
  output tcg_pkg::front_stat_t stat
);
  import tcg_pkg::*;

  logic [7:0]        col_r, col_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [31:0]       color_r, color_nxt;
  logic              esc_r, esc_nxt;
  logic [GCNT_W-1:0] total_r, total_nxt;
  logic              stop_r, stop_nxt;

  logic [7:0]        col_b, row_b, code, k;
  logic [31:0]       color_b;
  logic              esc_b, stop_b, accept, drawable;
  logic [GCNT_W-1:0] total_b, total_inc;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign code          = in_chan.text_byte;
  assign k             = code - first_code;
  assign drawable      = (code != CODE_SPACE) && (code >= first_code) && (k < table_size);

  always_comb begin
    // A frame start clears everything before the byte itself is looked at.
    col_b   = in_chan.frame_start ? 8'd0 : col_r;
    row_b   = in_chan.frame_start ? 8'd0 : row_r;
    color_b = in_chan.frame_start ? COLOR_WHITE : color_r;
    esc_b   = in_chan.frame_start ? 1'b0 : esc_r;
    total_b = in_chan.frame_start ? '0 : total_r;
    stop_b  = in_chan.frame_start ? 1'b0 : stop_r;
    total_inc = total_b + GCNT_W'(1);

    col_nxt   = col_b;
    row_nxt   = row_b;
    color_nxt = color_b;
    esc_nxt   = esc_b;
    total_nxt = total_b;
    stop_nxt  = stop_b;
    push      = 1'b0;

    push_job.col          = col_b;
    push_job.row          = row_b;
    push_job.color        = color_b;
    push_job.k            = k;
    push_job.glyph_number = total_b[GNUM_W-1:0];
    push_job.limit_hit    = total_inc >= GCNT_W'(GLYPH_LIMIT);

    priority if (stop_b) begin
      // Output has stopped: the byte is dropped.
    end else if (esc_b) begin
      color_nxt = {widen2(code[7:6]), widen2(code[5:4]), widen2(code[3:2]),
                   widen2(code[1:0])};
      esc_nxt   = 1'b0;
    end else if (code == CODE_NEWLINE) begin
      col_nxt   = 8'd0;
      row_nxt   = sat_inc(row_b);
      color_nxt = COLOR_WHITE;
    end else if (code == CODE_ESCAPE) begin
      esc_nxt = 1'b1;
    end else if (!drawable) begin
      col_nxt = sat_inc(col_b);
    end else begin
      push      = accept;
      total_nxt = total_inc;
      col_nxt   = sat_inc(col_b);
      stop_nxt  = push_job.limit_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= 8'd0;
      row_r   <= 8'd0;
      color_r <= COLOR_WHITE;
      esc_r   <= 1'b0;
      total_r <= '0;
      stop_r  <= 1'b0;
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      color_r <= color_nxt;
      esc_r   <= esc_nxt;
      total_r <= total_nxt;
      stop_r  <= stop_nxt;
    end
  end

  assign stat.stopped     = stop_r;
  assign stat.glyph_total = total_r;

endmodule

### rtl/core/tcg_queue.sv
`timescale 1ns / 1ps
module tcg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcg_pkg::job_t push_job,
  input  logic          pop,
  output tcg_pkg::job_t pop_job,
  output logic          full,
  output logic          empty
);
  import tcg_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/tcg_back.sv
`timescale 1ns / 1ps
module tcg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    table_size,
  input  logic          q_empty,
  input  tcg_pkg::job_t pop_job,
  output logic          pop,
  output logic          busy,
  tcg_out_if.source     out_chan
);
  import tcg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  job_t              job_r;
  logic [7:0]        rem_a_r, rem_b_r;
  logic [15:0]       num_a_r, num_b_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  job_t              out_job_r;
  logic [15:0]       out_left_r, out_right_r;

  logic [23:0] numer_a, numer_b;
  logic [7:0]  k1;
  logic [8:0]  trial_a, trial_b, size9;
  logic        ge_a, ge_b, load_out;

  // 65535*k is k shifted up by 16 minus k.
  assign k1      = pop_job.k + 8'd1;
  assign numer_a = {pop_job.k, 16'h0000} - {16'h0000, pop_job.k};
  assign numer_b = {k1, 16'h0000} - {16'h0000, k1};

  // One restoring division step for each of the two quotients.
  assign size9   = {1'b0, table_size};
  assign trial_a = {rem_a_r, num_a_r[15]};
  assign trial_b = {rem_b_r, num_b_r[15]};
  assign ge_a    = trial_a >= size9;
  assign ge_b    = trial_b >= size9;

  assign pop      = (state_r == ST_IDLE) && !q_empty;
  assign busy     = (state_r != ST_IDLE);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_empty) begin
        state_nxt = ST_DIV;
      end
      ST_DIV: if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        state_nxt = ST_DONE;
      end
      ST_DONE: if (load_out) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r   <= pop_job;
      rem_a_r <= numer_a[23:16];
      num_a_r <= numer_a[15:0];
      rem_b_r <= numer_b[23:16];
      num_b_r <= numer_b[15:0];
    end else if (state_r == ST_DIV) begin
      rem_a_r <= ge_a ? 8'(trial_a - size9) : trial_a[7:0];
      rem_b_r <= ge_b ? 8'(trial_b - size9) : trial_b[7:0];
      num_a_r <= {num_a_r[14:0], ge_a};
      num_b_r <= {num_b_r[14:0], ge_b};
    end
    if (load_out) begin
      out_job_r   <= job_r;
      out_left_r  <= num_a_r;
      out_right_r <= num_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        step_r <= '0;
      end else if (state_r == ST_DIV) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.cell_column  = out_job_r.col;
  assign out_chan.cell_row     = out_job_r.row;
  assign out_chan.tex_left     = out_left_r;
  assign out_chan.tex_right    = out_right_r;
  assign out_chan.red          = out_job_r.color[7:0];
  assign out_chan.green        = out_job_r.color[15:8];
  assign out_chan.blue         = out_job_r.color[23:16];
  assign out_chan.alpha        = out_job_r.color[31:24];
  assign out_chan.glyph_number = out_job_r.glyph_number;
  assign out_chan.limit_hit    = out_job_r.limit_hit;

endmodule

### rtl/core/text_console_glyph_generator.sv
// Path: the word for a drawable character passes the queue, the divider (16
// quotient steps) and the output register before it is valid at the output;
// other bytes give no word.
// Throughput: one byte per cycle until the two-entry queue fills; the divider
// then sets the pace, taking a new drawable character only when it is idle.
// Reset (rst_n, synchronous, active low) restores white, position zero, an empty
// queue and the default font table registers.
`timescale 1ns / 1ps
module text_console_glyph_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  tcg_in_if.sink                        in_chan,
  tcg_out_if.source                     out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tcg_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import tcg_pkg::*;

  // Font table registers. Register 0 (first_code) sits at byte address 0 and
  // register 1 (table_size) at byte address 4; only address bit 2 is decoded.
  logic [7:0] first_code_r, table_size_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = cfg_paddr[2] ? {24'h0, table_size_r} : {24'h0, first_code_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_code_r <= FIRST_CODE_RST;
      table_size_r <= TABLE_SIZE_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        table_size_r <= cfg_pwdata[7:0];
      end else begin
        first_code_r <= cfg_pwdata[7:0];
      end
    end
  end

  // The front tracks cursor, color and glyph count and forwards each drawable
  // character as a job up to the glyph limit. The queue lets it keep going
  // while the back works out the two texture coordinates by serial division.
  logic        push, pop, q_full, q_empty, back_busy;
  job_t        push_job, pop_job;
  front_stat_t front_stat;

  tcg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .first_code (first_code_r),
    .table_size (table_size_r),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job),
    .stat       (front_stat)
  );

  tcg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  tcg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_size (table_size_r),
    .q_empty    (q_empty),
    .pop_job    (pop_job),
    .pop        (pop),
    .busy       (back_busy),
    .out_chan   (out_chan)
  );

  // The queue must never be written while it is full.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("glyph job pushed into a full queue");

  // Once the glyph limit is reached, nothing is queued until a new frame.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !in_chan.frame_start) |-> !front_stat.stopped)
    else $error("glyph queued after the glyph limit");

  // The glyph count of a frame never runs past the limit.
  assert property (@(posedge clk) disable iff (!rst_n)
                   front_stat.glyph_total <= GCNT_W'(GLYPH_LIMIT))
    else $error("glyph count beyond the glyph limit");

  // A job is taken from the queue only while the divider is free.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !back_busy)
    else $error("queue popped while the divider is busy");

  // The right edge of a glyph never lies left of its left edge.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_chan.valid |-> (out_chan.tex_left <= out_chan.tex_right))
    else $error("texture coordinates out of order");

endmodule
